[rtl/sdh_pkg.sv]
// Shared types and constants for the step direction histogram.
// Used by sdh_dir and step_direction_histogram_unit; no dependencies.
`default_nettype none

package sdh_pkg;

    localparam int POS_BITS     = 24;
    localparam int DIFF_BITS    = POS_BITS + 1;
    localparam int MAG_BITS     = POS_BITS;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int SUMSQ_BITS   = SQ_BITS + 1;
    localparam int XY_BITS      = MAG_BITS + 1;
    localparam int XY_SQ_BITS   = 2 * XY_BITS;
    localparam int THR_BITS     = 40;
    localparam int SECTORS      = 16;
    localparam int SECTOR_BITS  = 4;
    localparam int BIN_W        = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [THR_BITS-1:0] MIN_STEP_SQ_RST = THR_BITS'(41);

    localparam logic KIND_STEP    = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef struct packed {
        logic signed [POS_BITS-1:0] east_offset;
        logic signed [POS_BITS-1:0] north_offset;
        logic                       first_frame;
        logic                       last_frame;
    } t_in_word;

    typedef struct packed {
        logic                   report_kind;
        logic [SECTOR_BITS-1:0] sector;
        logic [BIN_W-1:0]       bin_count;
        logic                   moved;
        logic                   end_of_run;
    } t_out_word;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] de;
        logic signed [DIFF_BITS-1:0] dn;
        logic                        formed;
        logic                        first;
        logic                        last;
    } t_step;

    typedef struct packed {
        logic                   moved;
        logic [SECTOR_BITS-1:0] sector;
        logic                   first;
        logic                   last;
    } t_move;

endpackage

`default_nettype wire

[rtl/step_direction_histogram_unit.sv]
// Step direction histogram top level: step former, counts, readout, output register.
// Depends on sdh_pkg and sdh_dir.
// A step report word passes r1_step, the sdh_dir stages r2 to r4 and the output register.
// Throughput: one input word per cycle; a last_frame word adds 16 readout words,
// during which the input is stalled. An output stall holds the pipe.
// Reset: threshold 41, all counts zero, no previous position, no words in flight.
`default_nettype none

module step_direction_histogram_unit #(
    parameter int COUNT_BITS = sdh_pkg::COUNT_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  sdh_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output sdh_pkg::t_out_word           o_out_word,
    input  wire                          i_cfg_we,
    input  wire [sdh_pkg::THR_BITS-1:0]  i_cfg_wdata
);

    logic [sdh_pkg::THR_BITS-1:0]        r_min_step_sq;
    logic signed [sdh_pkg::POS_BITS-1:0] r_prev_e, r_prev_n;
    logic                                r_have_prev;
    logic                                r1_valid;
    sdh_pkg::t_step                      r1_step;
    logic [COUNT_BITS-1:0]               r_cnt [sdh_pkg::SECTORS];
    logic                                r_rd_busy;
    logic [sdh_pkg::SECTOR_BITS-1:0]     r_rd_idx;
    logic                                r_out_valid;
    sdh_pkg::t_out_word                  r_out;

    logic                                out_free, adv, in_acc;
    logic                                mv_valid;
    sdh_pkg::t_move                      mv;
    logic [COUNT_BITS-1:0]               n_sel, n_inc, n_rd;
    logic [sdh_pkg::BIN_W+COUNT_BITS-1:0] n_inc_ext, n_rd_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = out_free && !r_rd_busy;
    assign in_acc     = i_in_valid && adv;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step_sq <= sdh_pkg::MIN_STEP_SQ_RST;
        end else if (i_cfg_we) begin
            r_min_step_sq <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r1_valid    <= 1'b0;
        end else begin
            if (adv) begin
                r1_valid <= in_acc;
            end
            if (in_acc) begin
                r_have_prev <= 1'b1;
            end
        end
        if (in_acc) begin
            r_prev_e       <= i_in_word.east_offset;
            r_prev_n       <= i_in_word.north_offset;
            r1_step.de     <= {i_in_word.east_offset[sdh_pkg::POS_BITS-1],
                               i_in_word.east_offset} - {r_prev_e[sdh_pkg::POS_BITS-1], r_prev_e};
            r1_step.dn     <= {i_in_word.north_offset[sdh_pkg::POS_BITS-1],
                               i_in_word.north_offset} - {r_prev_n[sdh_pkg::POS_BITS-1], r_prev_n};
            r1_step.formed <= r_have_prev && !i_in_word.first_frame;
            r1_step.first  <= i_in_word.first_frame;
            r1_step.last   <= i_in_word.last_frame;
        end
    end

    sdh_dir u_dir (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (r1_valid),
        .i_step        (r1_step),
        .i_min_step_sq (r_min_step_sq),
        .o_valid       (mv_valid),
        .o_move        (mv)
    );

    always_comb begin
        n_sel     = r_cnt[mv.sector];
        n_inc     = (n_sel == '1) ? n_sel : n_sel + COUNT_BITS'(1);
        n_rd      = r_cnt[r_rd_idx];
        n_inc_ext = {{sdh_pkg::BIN_W{1'b0}}, n_inc};
        n_rd_ext  = {{sdh_pkg::BIN_W{1'b0}}, n_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sdh_pkg::SECTORS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (adv && mv_valid) begin
            for (int i = 0; i < sdh_pkg::SECTORS; i++) begin
                if (mv.first) begin
                    r_cnt[i] <= '0;
                end else if (mv.moved && mv.sector == sdh_pkg::SECTOR_BITS'(i)) begin
                    r_cnt[i] <= n_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rd_busy   <= 1'b0;
            r_rd_idx    <= '0;
        end else if (out_free) begin
            if (r_rd_busy) begin
                r_out_valid <= 1'b1;
                r_rd_idx    <= r_rd_idx + 1'b1;
                if (r_rd_idx == sdh_pkg::SECTOR_BITS'(sdh_pkg::SECTORS - 1)) begin
                    r_rd_busy <= 1'b0;
                end
            end else if (mv_valid) begin
                r_out_valid <= 1'b1;
                r_rd_busy   <= mv.last;
                r_rd_idx    <= '0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
        if (out_free) begin
            if (r_rd_busy) begin
                r_out.report_kind <= sdh_pkg::KIND_READOUT;
                r_out.sector      <= r_rd_idx;
                r_out.bin_count   <= n_rd_ext[sdh_pkg::BIN_W-1:0];
                r_out.moved       <= 1'b0;
                r_out.end_of_run  <= r_rd_idx == sdh_pkg::SECTOR_BITS'(sdh_pkg::SECTORS - 1);
            end else begin
                r_out.report_kind <= sdh_pkg::KIND_STEP;
                r_out.sector      <= mv.moved ? mv.sector : '0;
                r_out.bin_count   <= mv.moved ? n_inc_ext[sdh_pkg::BIN_W-1:0] : '0;
                r_out.moved       <= mv.moved;
                r_out.end_of_run  <= !mv.last;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_busy_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_busy |-> r_out_valid)
        else $error("readout active with empty output register");

    a_busy_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_busy |-> o_in_stall)
        else $error("input taken during readout");

    a_readout_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.report_kind == sdh_pkg::KIND_READOUT
         && o_out_word.end_of_run)
        |-> o_out_word.sector == sdh_pkg::SECTOR_BITS'(sdh_pkg::SECTORS - 1))
        else $error("readout ended before last bin");

    a_still_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.report_kind == sdh_pkg::KIND_STEP && !o_out_word.moved)
        |-> (o_out_word.sector == '0 && o_out_word.bin_count == '0))
        else $error("step word without move carries a bin");

    a_readout_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.report_kind == sdh_pkg::KIND_STEP
         && !o_out_word.end_of_run)
        |=> (o_out_valid && o_out_word.report_kind == sdh_pkg::KIND_READOUT
             && o_out_word.sector == '0))
        else $error("readout did not follow last frame");

endmodule

`default_nettype wire

[rtl/sdh_dir.sv]
// Three-stage step classifier: magnitudes and quadrant, squares, threshold and sector.
// Depends on sdh_pkg.
`default_nettype none

module sdh_dir (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_adv,
    input  wire                               i_valid,
    input  sdh_pkg::t_step                    i_step,
    input  wire [sdh_pkg::THR_BITS-1:0]       i_min_step_sq,
    output logic                              o_valid,
    output sdh_pkg::t_move                    o_move
);

    // stage 2: magnitudes, quadrant, x and y
    logic                              r2_valid;
    logic [sdh_pkg::MAG_BITS-1:0]      r2_ae, r2_an, r2_x, r2_dif;
    logic [sdh_pkg::XY_BITS-1:0]       r2_sum;
    logic                              r2_ygex, r2_zero, r2_formed, r2_first, r2_last;
    logic [1:0]                        r2_q;

    // stage 3: squares
    logic                              r3_valid;
    logic [sdh_pkg::SQ_BITS-1:0]       r3_sq_e, r3_sq_n, r3_x2, r3_d2;
    logic [sdh_pkg::XY_SQ_BITS-1:0]    r3_s2;
    logic                              r3_ygex, r3_zero, r3_formed, r3_first, r3_last;
    logic [1:0]                        r3_q;

    // stage 4: result
    logic                              r4_valid;
    sdh_pkg::t_move                    r4_move;

    logic [sdh_pkg::DIFF_BITS-1:0]     n_ae_full, n_an_full;
    logic [sdh_pkg::MAG_BITS-1:0]      n_ae, n_an, n_x, n_y;
    logic [1:0]                        n_q;
    logic                              n_zero;

    always_comb begin
        n_ae_full = i_step.de[sdh_pkg::DIFF_BITS-1] ? -i_step.de : i_step.de;
        n_an_full = i_step.dn[sdh_pkg::DIFF_BITS-1] ? -i_step.dn : i_step.dn;
        n_ae = n_ae_full[sdh_pkg::MAG_BITS-1:0];
        n_an = n_an_full[sdh_pkg::MAG_BITS-1:0];
        n_zero = 1'b0;
        n_q = 2'd0;
        if (i_step.de > 0 && i_step.dn >= 0) begin
            n_q = 2'd0;
        end else if (i_step.de <= 0 && i_step.dn > 0) begin
            n_q = 2'd1;
        end else if (i_step.de < 0 && i_step.dn <= 0) begin
            n_q = 2'd2;
        end else if (i_step.de >= 0 && i_step.dn < 0) begin
            n_q = 2'd3;
        end else begin
            n_zero = 1'b1;
        end
        n_x = n_q[0] ? n_an : n_ae;
        n_y = n_q[0] ? n_ae : n_an;
    end

    logic [sdh_pkg::SUMSQ_BITS-1:0]    n_len2, n_thr, n_two_x2;
    logic                              n_cmp_s, n_cmp_d;
    logic [1:0]                        n_s;

    always_comb begin
        n_len2   = sdh_pkg::SUMSQ_BITS'(r3_sq_e) + sdh_pkg::SUMSQ_BITS'(r3_sq_n);
        n_thr    = sdh_pkg::SUMSQ_BITS'(i_min_step_sq);
        n_two_x2 = {r3_x2, 1'b0};
        n_cmp_s  = r3_s2 >= sdh_pkg::XY_SQ_BITS'(n_two_x2);
        n_cmp_d  = sdh_pkg::SUMSQ_BITS'(r3_d2) >= n_two_x2;
        n_s      = 2'(n_cmp_s) + 2'(r3_ygex) + 2'(r3_ygex & n_cmp_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= i_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
        if (i_adv) begin
            r2_ae     <= n_ae;
            r2_an     <= n_an;
            r2_x      <= n_x;
            r2_sum    <= sdh_pkg::XY_BITS'(n_x) + sdh_pkg::XY_BITS'(n_y);
            r2_ygex   <= n_y >= n_x;
            r2_dif    <= (n_y >= n_x) ? n_y - n_x : '0;
            r2_q      <= n_q;
            r2_zero   <= n_zero;
            r2_formed <= i_step.formed;
            r2_first  <= i_step.first;
            r2_last   <= i_step.last;

            r3_sq_e   <= sdh_pkg::SQ_BITS'(r2_ae) * sdh_pkg::SQ_BITS'(r2_ae);
            r3_sq_n   <= sdh_pkg::SQ_BITS'(r2_an) * sdh_pkg::SQ_BITS'(r2_an);
            r3_x2     <= sdh_pkg::SQ_BITS'(r2_x) * sdh_pkg::SQ_BITS'(r2_x);
            r3_d2     <= sdh_pkg::SQ_BITS'(r2_dif) * sdh_pkg::SQ_BITS'(r2_dif);
            r3_s2     <= sdh_pkg::XY_SQ_BITS'(r2_sum) * sdh_pkg::XY_SQ_BITS'(r2_sum);
            r3_ygex   <= r2_ygex;
            r3_q      <= r2_q;
            r3_zero   <= r2_zero;
            r3_formed <= r2_formed;
            r3_first  <= r2_first;
            r3_last   <= r2_last;

            r4_move.moved  <= r3_formed && (n_len2 >= n_thr);
            r4_move.sector <= (r3_formed && (n_len2 >= n_thr) && !r3_zero) ?
                              {r3_q, n_s} : '0;
            r4_move.first  <= r3_first;
            r4_move.last   <= r3_last;
        end
    end

    assign o_valid = r4_valid;
    assign o_move  = r4_move;

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for step_direction_histogram_unit: frame positions in, step and count
// reports out. Needs sdh_pkg and the RTL; every report is predicted in-bench and checked in order.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = 8;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    sdh_pkg::t_in_word            i_in_word   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    sdh_pkg::t_out_word           o_out_word;
    logic                         i_cfg_we    = 1'b0;
    logic [sdh_pkg::THR_BITS-1:0] i_cfg_wdata = '0;

    sdh_pkg::t_in_word    pending_frames[$];
    sdh_pkg::t_out_word   expected_reports[$];
    sdh_pkg::t_out_word   want;

    logic [sdh_pkg::THR_BITS-1:0]       min_sq = sdh_pkg::MIN_STEP_SQ_RST;
    logic signed [sdh_pkg::POS_BITS-1:0] last_east = '0;
    logic signed [sdh_pkg::POS_BITS-1:0] last_north = '0;
    logic                                have_last = 1'b0;
    logic [sdh_pkg::BIN_W-1:0]           sector_tally[sdh_pkg::SECTORS];

    logic signed [sdh_pkg::POS_BITS-1:0] walk_east = '0;
    logic signed [sdh_pkg::POS_BITS-1:0] walk_north = '0;

    int unsigned send_gap_pct  = 0;
    int unsigned stall_pct     = 0;
    logic        long_hold_arm = 1'b0;
    logic        hold_taken    = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;
    int unsigned fail_count    = 0;

    step_direction_histogram_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic void add_frame(input sdh_pkg::t_in_word w);
        pending_frames.insert(pending_frames.size(), w);
    endfunction

    function automatic void add_report(input sdh_pkg::t_out_word r);
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic logic [sdh_pkg::SECTOR_BITS-1:0] step_sector(
        input logic signed [sdh_pkg::DIFF_BITS-1:0] de,
        input logic signed [sdh_pkg::DIFF_BITS-1:0] dn);
        logic [sdh_pkg::DIFF_BITS-1:0] ae, an;
        logic [63:0]                   run, rise, twice_run_sq;
        logic [1:0]                    quad;
        logic [1:0]                    part;
        logic                          e_pos, e_neg, n_pos, n_neg;
        ae = de[sdh_pkg::DIFF_BITS-1] ? -de : de;
        an = dn[sdh_pkg::DIFF_BITS-1] ? -dn : dn;
        e_neg = de[sdh_pkg::DIFF_BITS-1];
        n_neg = dn[sdh_pkg::DIFF_BITS-1];
        e_pos = !e_neg && (de != 0);
        n_pos = !n_neg && (dn != 0);
        if (e_pos && !n_neg) begin
            quad = 2'd0; run = 64'(ae); rise = 64'(an);
        end else if (!e_pos && n_pos) begin
            quad = 2'd1; run = 64'(an); rise = 64'(ae);
        end else if (e_neg && !n_pos) begin
            quad = 2'd2; run = 64'(ae); rise = 64'(an);
        end else if (!e_neg && n_neg) begin
            quad = 2'd3; run = 64'(an); rise = 64'(ae);
        end else begin
            return '0;
        end
        twice_run_sq = (run * run) << 1;
        part = 2'd0;
        if ((run + rise) * (run + rise) >= twice_run_sq)
            part = part + 2'd1;
        if (rise >= run) begin
            part = part + 2'd1;
            if ((rise - run) * (rise - run) >= twice_run_sq)
                part = part + 2'd1;
        end
        return {quad, part};
    endfunction

    task automatic predict_reports(input sdh_pkg::t_in_word w);
        logic signed [sdh_pkg::DIFF_BITS-1:0] de, dn;
        logic [sdh_pkg::DIFF_BITS-1:0]        ae, an;
        logic [sdh_pkg::SUMSQ_BITS:0]         len_sq;
        logic [sdh_pkg::SECTOR_BITS-1:0]      sec;
        logic [sdh_pkg::BIN_W-1:0]            cnt;
        logic                                 hit;
        sdh_pkg::t_out_word                   r;
        sec = '0;
        cnt = '0;
        hit = 1'b0;
        if (w.first_frame) begin
            foreach (sector_tally[i]) sector_tally[i] = '0;
        end else if (have_last) begin
            de = {w.east_offset[sdh_pkg::POS_BITS-1], w.east_offset}
                 - {last_east[sdh_pkg::POS_BITS-1], last_east};
            dn = {w.north_offset[sdh_pkg::POS_BITS-1], w.north_offset}
                 - {last_north[sdh_pkg::POS_BITS-1], last_north};
            ae = de[sdh_pkg::DIFF_BITS-1] ? -de : de;
            an = dn[sdh_pkg::DIFF_BITS-1] ? -dn : dn;
            len_sq = (sdh_pkg::SUMSQ_BITS+1)'(ae) * (sdh_pkg::SUMSQ_BITS+1)'(ae)
                     + (sdh_pkg::SUMSQ_BITS+1)'(an) * (sdh_pkg::SUMSQ_BITS+1)'(an);
            if (len_sq >= (sdh_pkg::SUMSQ_BITS+1)'(min_sq)) begin
                hit = 1'b1;
                sec = step_sector(de, dn);
                if (sector_tally[sec] != {sdh_pkg::BIN_W{1'b1}})
                    sector_tally[sec] = sector_tally[sec] + 1'b1;
                cnt = sector_tally[sec];
            end
        end
        last_east  = w.east_offset;
        last_north = w.north_offset;
        have_last  = 1'b1;
        r.report_kind = sdh_pkg::KIND_STEP;
        r.sector      = sec;
        r.bin_count   = cnt;
        r.moved       = hit;
        r.end_of_run  = !w.last_frame;
        add_report(r);
        if (w.last_frame) begin
            for (int i = 0; i < sdh_pkg::SECTORS; i++) begin
                r.report_kind = sdh_pkg::KIND_READOUT;
                r.sector      = sdh_pkg::SECTOR_BITS'(i);
                r.bin_count   = sector_tally[i];
                r.moved       = 1'b0;
                r.end_of_run  = (i == sdh_pkg::SECTORS - 1);
                add_report(r);
            end
        end
    endtask

    task automatic queue_frame(input int e, input int n, input bit first, input bit last);
        sdh_pkg::t_in_word w;
        w.east_offset  = sdh_pkg::POS_BITS'(e);
        w.north_offset = sdh_pkg::POS_BITS'(n);
        w.first_frame  = first;
        w.last_frame   = last;
        add_frame(w);
    endtask

    task automatic queue_walk(input int unsigned frames);
        sdh_pkg::t_in_word w;
        int unsigned       k;
        int                m;
        bit                tidy;
        tidy = ($urandom_range(4) != 0);
        if ($urandom_range(1) == 0) begin
            walk_east  = sdh_pkg::POS_BITS'($urandom);
            walk_north = sdh_pkg::POS_BITS'($urandom);
        end
        for (k = 0; k < frames; k++) begin
            case ($urandom_range(7))
                0, 1, 2: begin
                    walk_east  = walk_east + sdh_pkg::POS_BITS'(int'($urandom_range(24)) - 12);
                    walk_north = walk_north + sdh_pkg::POS_BITS'(int'($urandom_range(24)) - 12);
                end
                3: begin
                    walk_east  = walk_east
                                 + sdh_pkg::POS_BITS'(int'($urandom_range(8191)) - 4096);
                    walk_north = walk_north
                                 + sdh_pkg::POS_BITS'(int'($urandom_range(8191)) - 4096);
                end
                4, 7: begin
                    walk_east  = sdh_pkg::POS_BITS'($urandom);
                    walk_north = sdh_pkg::POS_BITS'($urandom);
                end
                5: ;
                default: begin
                    m = int'($urandom_range(40, 1));
                    case ($urandom_range(7))
                        0: walk_east = walk_east + sdh_pkg::POS_BITS'(m);
                        1: walk_north = walk_north + sdh_pkg::POS_BITS'(m);
                        2: walk_east = walk_east - sdh_pkg::POS_BITS'(m);
                        3: walk_north = walk_north - sdh_pkg::POS_BITS'(m);
                        4: begin
                            walk_east  = walk_east + sdh_pkg::POS_BITS'(m);
                            walk_north = walk_north + sdh_pkg::POS_BITS'(m);
                        end
                        5: begin
                            walk_east  = walk_east - sdh_pkg::POS_BITS'(m);
                            walk_north = walk_north + sdh_pkg::POS_BITS'(m);
                        end
                        6: begin
                            walk_east  = walk_east - sdh_pkg::POS_BITS'(m);
                            walk_north = walk_north - sdh_pkg::POS_BITS'(m);
                        end
                        default: begin
                            walk_east  = walk_east + sdh_pkg::POS_BITS'(m);
                            walk_north = walk_north - sdh_pkg::POS_BITS'(m);
                        end
                    endcase
                end
            endcase
            w.east_offset  = walk_east;
            w.north_offset = walk_north;
            if (tidy) begin
                w.first_frame = (k == 0);
                w.last_frame  = (k == frames - 1);
            end else begin
                w.first_frame = ($urandom_range(7) == 0);
                w.last_frame  = ($urandom_range(7) == 0);
            end
            add_frame(w);
        end
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned done;
        int unsigned len;
        done = 0;
        while (done < count) begin
            len = $urandom_range(10, 2);
            if (len > count - done)
                len = count - done;
            queue_walk(len);
            done = done + len;
        end
    endtask

    task automatic write_threshold(input logic [sdh_pkg::THR_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        min_sq = v;
    endtask

    task automatic set_idling(input int unsigned gap, input int unsigned stall);
        @(posedge i_clk);
        send_gap_pct <= gap;
        stall_pct    <= stall;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_frames.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_in_word  <= pending_frames.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_taken  <= 1'b0;
        end else if (long_hold_arm && !hold_taken) begin
            i_out_stall <= 1'b1;
            hold_left   <= LONG_HOLD;
            hold_taken  <= 1'b1;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (!long_hold_arm)
                hold_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_reports(i_in_word);
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected word: kind %0d sector %0d count %0d",
                           o_out_word.report_kind, o_out_word.sector, o_out_word.bin_count);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_out_word.report_kind !== want.report_kind) begin
                        $error("report_kind: expected %0d, got %0d",
                               want.report_kind, o_out_word.report_kind);
                        fail_count++;
                    end
                    if (o_out_word.sector !== want.sector) begin
                        $error("sector: expected %0d, got %0d", want.sector, o_out_word.sector);
                        fail_count++;
                    end
                    if (o_out_word.bin_count !== want.bin_count) begin
                        $error("bin_count: expected %0d, got %0d",
                               want.bin_count, o_out_word.bin_count);
                        fail_count++;
                    end
                    if (o_out_word.moved !== want.moved) begin
                        $error("moved: expected %0d, got %0d", want.moved, o_out_word.moved);
                        fail_count++;
                    end
                    if (o_out_word.end_of_run !== want.end_of_run) begin
                        $error("end_of_run: expected %0d, got %0d",
                               want.end_of_run, o_out_word.end_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        foreach (sector_tally[i]) sector_tally[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_frame(100, 100, 0, 0);
        queue_frame(107, 100, 0, 0);
        queue_frame(113, 100, 0, 0);
        queue_frame(118, 104, 0, 0);
        queue_frame(118, 120, 0, 0);
        queue_frame(108, 130, 0, 0);
        queue_frame(98, 130, 0, 0);
        queue_frame(98, 110, 0, 0);
        queue_frame(108, 120, 0, 0);
        queue_frame(120, 100, 0, 0);
        queue_frame(8388607, 8388607, 0, 0);
        queue_frame(-8388608, -8388608, 0, 0);
        queue_frame(8388607, -8388608, 0, 0);
        queue_frame(-8388608, 8388607, 0, 0);
        queue_frame(0, 0, 0, 1);
        queue_frame(0, 50, 0, 0);
        queue_frame(0, 0, 1, 1);
        queue_frame(5, 0, 0, 0);
        queue_frame(5, 0, 1, 0);
        queue_frame(-3, -9, 0, 0);
        queue_frame(-3, -9, 0, 1);
        wait_drained();

        write_threshold('0);
        queue_frame(50, 60, 1, 0);
        queue_frame(50, 60, 0, 0);
        queue_frame(50, 60, 0, 1);
        queue_random(41);
        wait_drained();

        write_threshold(sdh_pkg::THR_BITS'($urandom_range(400)));
        set_idling(76, 0);
        queue_random(30);
        wait_drained();

        write_threshold({sdh_pkg::THR_BITS{1'b1}});
        set_idling(0, 76);
        queue_random(30);
        wait_drained();

        write_threshold(sdh_pkg::MIN_STEP_SQ_RST);
        set_idling(13, 13);
        queue_random(45);
        @(posedge i_clk);
        long_hold_arm <= 1'b1;
        wait_drained();
        long_hold_arm <= 1'b0;
        set_idling(0, 0);
        wait_drained();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/sdh_pkg.sv
rtl/sdh_dir.sv
rtl/step_direction_histogram_unit.sv
verif/tb_top.sv
